// ===== rtl/spcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcrc_pkg
// Shared types, constants and the byte-wise CRC-16 update for the status
// packet receiver.
// ----------------------------------------------------------------------------
package spcrc_pkg;

    localparam logic [15:0] CRC_POLY        = 16'h8005;
    localparam logic [7:0]  HDR_A           = 8'hFF;
    localparam logic [7:0]  HDR_C           = 8'hFD;
    localparam int          FIXED_BODY      = 6;
    localparam int          POS_ID          = 1;
    localparam int          POS_ERROR       = 5;
    localparam int          KEPT_BYTES      = 4;
    localparam int          COUNT_W         = 3;
    localparam logic [2:0]  PARAM_COUNT_RST = 3'd4;

    typedef enum logic [5:0] {
        ST_HUNT = 6'b000001,
        ST_HDR2 = 6'b000010,
        ST_HDR3 = 6'b000100,
        ST_BODY = 6'b001000,
        ST_CRCL = 6'b010000,
        ST_CRCH = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        packet_ok;
        logic        crc_match;
        logic [7:0]  error_code;
        logic [7:0]  device_id;
        logic [31:0] data_value;
    } t_result;

    // CRC-16, polynomial 0x8005, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/spcrc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcrc_if
// Valid/ready channels: received bytes, packet results, configuration.
// ----------------------------------------------------------------------------
interface spcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spcrc_out_if;
    logic        valid;
    logic        ready;
    logic        packet_ok;
    logic        crc_match;
    logic [7:0]  error_code;
    logic [7:0]  device_id;
    logic [31:0] data_value;

    modport source (output valid, output packet_ok, output crc_match,
                    output error_code, output device_id, output data_value,
                    input ready);
    modport sink   (input valid, input packet_ok, input crc_match,
                    input error_code, input device_id, input data_value,
                    output ready);
endinterface

interface spcrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] param_count;

    modport source (output valid, output param_count, input ready);
    modport sink   (input valid, input param_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/status_packet_crc16_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_packet_crc16_receiver_top
// Status packet receiver: header hunt 0xFF 0xFF 0xFD, field capture and
// CRC-16 (0x8005, init 0) check, one result per packet.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and reports each status packet once its
// CRC high byte arrives: CRC verdict, error byte, device id and up to four
// parameter bytes little-endian. A byte passes an input register, then the
// combinational CRC byte update and field capture, then the result register,
// so a packet's last byte passes both registers before its result is shown,
// and with no stall a byte is taken every cycle. While a result waits in the
// result register with o_res.ready low, the byte in the input register is
// held and the input stalls once that register is full.
// Write param_count only while no packet is in flight.
// ----------------------------------------------------------------------------
module status_packet_crc16_receiver_top #(
    parameter int MAX_PARAMS = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    spcrc_in_if.sink       i_rx,
    spcrc_cfg_if.sink      i_cfg,
    spcrc_out_if.source    o_res
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [2:0]          r_param_count;
    logic                r_out_valid;
    spcrc_pkg::t_result  r_out;

    logic                w_adv;
    logic                w_res_valid;
    spcrc_pkg::t_result  w_res;

    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    spcrc_deframer #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_deframer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_adv),
        .i_byte        (r_in_byte),
        .i_param_count (r_param_count),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_count <= spcrc_pkg::PARAM_COUNT_RST;
        end else if (i_cfg.valid) begin
            r_param_count <= i_cfg.param_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.packet_ok  = r_out.packet_ok;
    assign o_res.crc_match  = r_out.crc_match;
    assign o_res.error_code = r_out.error_code;
    assign o_res.device_id  = r_out.device_id;
    assign o_res.data_value = r_out.data_value;

endmodule
`default_nettype wire

// ===== rtl/spcrc_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcrc_deframer
// Header hunt, field capture and running CRC; one byte per enabled cycle,
// result formed combinationally on the CRC high byte.
// ----------------------------------------------------------------------------
module spcrc_deframer #(
    parameter int MAX_PARAMS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    input  wire logic [2:0]            i_param_count,
    output logic                       o_res_valid,
    output spcrc_pkg::t_result         o_res
);

    localparam int POS_W = $clog2(spcrc_pkg::FIXED_BODY + MAX_PARAMS + 1);
    localparam int KEEP  = (MAX_PARAMS < spcrc_pkg::KEPT_BYTES) ?
                           MAX_PARAMS : spcrc_pkg::KEPT_BYTES;

    spcrc_pkg::t_phase  r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_id, n_id;
    logic [7:0]         r_err, n_err;
    logic [31:0]        r_data, n_data;
    logic [7:0]         r_low, n_low;

    logic [POS_W-1:0]   w_count;
    logic [POS_W-1:0]   w_pos_next;
    logic               w_is_a;
    logic [15:0]        w_crc_upd;
    logic [15:0]        w_got;

    assign w_is_a     = (i_byte == spcrc_pkg::HDR_A);
    assign w_crc_upd  = spcrc_pkg::crc16_byte(r_crc, i_byte);
    assign w_pos_next = r_pos + POS_W'(1);
    assign w_got      = {i_byte, r_low};

    always_comb begin
        if (i_param_count == '0) begin
            w_count = POS_W'(1);
        end else if (int'(i_param_count) > MAX_PARAMS) begin
            w_count = POS_W'(MAX_PARAMS);
        end else begin
            w_count = POS_W'(i_param_count);
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_id    = r_id;
        n_err   = r_err;
        n_data  = r_data;
        n_low   = r_low;

        o_res_valid      = 1'b0;
        o_res.crc_match  = (w_got == r_crc);
        o_res.packet_ok  = (w_got == r_crc) && (r_err == 8'h00);
        o_res.error_code = r_err;
        o_res.device_id  = r_id;
        o_res.data_value = r_data;

        if (i_valid) begin
            unique case (r_phase)
                spcrc_pkg::ST_BODY: begin
                    n_crc = w_crc_upd;
                    if (r_pos == POS_W'(spcrc_pkg::POS_ID)) begin
                        n_id = i_byte;
                    end
                    if (r_pos == POS_W'(spcrc_pkg::POS_ERROR)) begin
                        n_err = i_byte;
                    end
                    for (int k = 0; k < KEEP; k++) begin
                        if (r_pos == POS_W'(spcrc_pkg::FIXED_BODY + k)) begin
                            n_data[8*k +: 8] = i_byte;
                        end
                    end
                    if (w_pos_next >= POS_W'(spcrc_pkg::FIXED_BODY) + w_count) begin
                        n_phase = spcrc_pkg::ST_CRCL;
                        n_pos   = '0;
                    end else begin
                        n_pos   = w_pos_next;
                    end
                end
                spcrc_pkg::ST_CRCL: begin
                    n_low   = i_byte;
                    n_phase = spcrc_pkg::ST_CRCH;
                end
                spcrc_pkg::ST_CRCH: begin
                    o_res_valid = 1'b1;
                    n_phase = spcrc_pkg::ST_HUNT;
                    n_pos   = '0;
                    n_crc   = '0;
                    n_id    = '0;
                    n_err   = '0;
                    n_data  = '0;
                    n_low   = '0;
                end
                default: begin
                    // header bytes: advance on match, restart otherwise
                    if (r_phase == spcrc_pkg::ST_HDR2 && w_is_a) begin
                        n_crc   = w_crc_upd;
                        n_phase = spcrc_pkg::ST_HDR3;
                    end else if (r_phase == spcrc_pkg::ST_HDR3 &&
                                 i_byte == spcrc_pkg::HDR_C) begin
                        n_crc   = w_crc_upd;
                        n_phase = spcrc_pkg::ST_BODY;
                        n_pos   = '0;
                    end else begin
                        n_pos   = '0;
                        n_id    = '0;
                        n_err   = '0;
                        n_data  = '0;
                        n_low   = '0;
                        if (w_is_a) begin
                            n_crc   = spcrc_pkg::crc16_byte(16'h0000, spcrc_pkg::HDR_A);
                            n_phase = spcrc_pkg::ST_HDR2;
                        end else begin
                            n_crc   = '0;
                            n_phase = spcrc_pkg::ST_HUNT;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spcrc_pkg::ST_HUNT;
            r_pos   <= '0;
            r_crc   <= '0;
            r_id    <= '0;
            r_err   <= '0;
            r_data  <= '0;
            r_low   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_id    <= n_id;
            r_err   <= n_err;
            r_data  <= n_data;
            r_low   <= n_low;
        end
    end

endmodule
`default_nettype wire
